[src/ata_pkg.sv]
// Shared types and constants for the affine transform accumulator.
package ata_pkg;

  localparam int DATA_W      = 32;
  localparam int MAT_AW      = 4;
  localparam int MAT_DEPTH   = 16;
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_SCALE     = 2'd1,
    OP_POINT     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // One term issued to the multiply-accumulate unit
  typedef struct packed {
    logic              valid;
    logic              is_prod;  // matrix entry times argument, else entry times one
    logic              first;    // start a new sum
    logic              last;     // sum complete, write it back
    logic              to_mem;   // write back into the matrix, else into the point result
    logic [1:0]        arg_sel;  // 0 arg_a, 1 arg_b, 2 arg_c
    logic [MAT_AW-1:0] rd_addr;
    logic [MAT_AW-1:0] dst;      // matrix entry, or result row in the upper bits
  } term_t;

endpackage

[src/affine_transform_accumulator.sv]
// Top level: 4x4 homogeneous transform accumulator with a stream request and result port.
//
// Keeps a 4x4 signed fixed-point transform matrix, identity after reset. A request
// carries an opcode and three arguments: translate and scale left-multiply the matrix
// and give no result, transform point returns the first three rows of M*(x,y,z,1) with
// a flag that is set if any matrix entry or coordinate saturated since the previous
// point result. Opcode 3 is taken and ignored. One multiply-accumulate unit fed by a
// single matrix read port handles one term per cycle: translate issues 24 terms, scale
// 12 and a point 12, after which the point result is loaded once the previous result
// has been taken. Opcode 3 issues no terms.
module affine_transform_accumulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] arg_a, [63:32] arg_b, [95:64] arg_c
  input  logic [ata_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [1:0] opcode
  input  logic [ata_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [ata_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [0] saturated
  output logic                                m_axis_tuser_o
);
  import ata_pkg::*;

  logic                     in_accept;
  logic                     in_ready;
  logic                     load_out;
  logic                     out_free;
  term_t                    term;
  logic signed [DATA_W-1:0] arg_a_q, arg_b_q, arg_c_q;
  logic signed [DATA_W-1:0] rd_data;
  logic                     wr_en;
  logic [MAT_AW-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] res_x, res_y, res_z;
  logic                     sat;
  logic                     m_valid_q, m_valid_d;
  logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                     out_sat_q;

  assign in_accept = s_axis_tvalid_i && in_ready;
  assign out_free  = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      arg_a_q <= s_axis_tdata_i[31:0];
      arg_b_q <= s_axis_tdata_i[63:32];
      arg_c_q <= s_axis_tdata_i[95:64];
    end
  end

  ata_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .load_out_o (load_out),
    .term_o     (term)
  );

  ata_matrix_mem #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (term.rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ata_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .term_i    (term),
    .rd_data_i (rd_data),
    .arg_a_i   (arg_a_q),
    .arg_b_i   (arg_b_q),
    .arg_c_i   (arg_c_q),
    .clr_i     (load_out),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .res_x_o   (res_x),
    .res_y_o   (res_y),
    .res_z_o   (res_z),
    .sat_o     (sat)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q   <= res_x;
      out_y_q   <= res_y;
      out_z_q   <= res_z;
      out_sat_q <= sat;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_z_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_sat_q;

endmodule

[src/ata_matrix_mem.sv]
// Transform matrix storage: 16-entry memory with per-entry valid bits, identity when unwritten.
module ata_matrix_mem #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ata_pkg::MAT_AW-1:0]       rd_addr_i,
  output logic signed [ata_pkg::DATA_W-1:0] rd_data_o,
  input  logic                             wr_en_i,
  input  logic [ata_pkg::MAT_AW-1:0]       wr_addr_i,
  input  logic signed [ata_pkg::DATA_W-1:0] wr_data_i
);
  import ata_pkg::*;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(64'd1 << FRAC_BITS);

  logic signed [DATA_W-1:0] mem_q [MAT_DEPTH];
  logic [MAT_DEPTH-1:0]     valid_q;
  logic signed [DATA_W-1:0] rd_data_q;
  logic signed [DATA_W-1:0] ident;

  // Diagonal entries read as one until written
  assign ident = (rd_addr_i[3:2] == rd_addr_i[1:0]) ? Q_ONE : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : ident;
  end

  assign rd_data_o = rd_data_q;

  // The bottom row of a homogeneous transform never changes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> wr_addr_i[3:2] != 2'd3)
    else $error("write to the fixed bottom row");

endmodule

[src/ata_mac.sv]
// Shared multiply-accumulate unit with truncating shift, saturation and write-back.
module ata_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ata_pkg::term_t                    term_i,
  input  logic signed [ata_pkg::DATA_W-1:0] rd_data_i,
  input  logic signed [ata_pkg::DATA_W-1:0] arg_a_i,
  input  logic signed [ata_pkg::DATA_W-1:0] arg_b_i,
  input  logic signed [ata_pkg::DATA_W-1:0] arg_c_i,
  input  logic                              clr_i,
  output logic                              wr_en_o,
  output logic [ata_pkg::MAT_AW-1:0]        wr_addr_o,
  output logic signed [ata_pkg::DATA_W-1:0] wr_data_o,
  output logic signed [ata_pkg::DATA_W-1:0] res_x_o,
  output logic signed [ata_pkg::DATA_W-1:0] res_y_o,
  output logic signed [ata_pkg::DATA_W-1:0] res_z_o,
  output logic                              sat_o
);
  import ata_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 2;
  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  term_t                    tag1_q, tag2_q;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  sum;
  logic signed [TERM_W-1:0] shifted;
  logic [ACC_W-DATA_W:0]    upper;
  logic                     ovf;
  logic signed [DATA_W-1:0] sat_val;
  logic signed [DATA_W-1:0] res_q [3];
  logic                     pt_flag_q;
  logic                     sat_seen_q;
  logic                     wb;

  always_comb begin
    unique case (tag1_q.arg_sel)
      2'd0:    mul_b = arg_a_i;
      2'd1:    mul_b = arg_b_i;
      default: mul_b = arg_c_i;
    endcase
    // An addend passes through the multiplier as entry times one
    if (!tag1_q.is_prod) begin
      mul_b = Q_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= term_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= rd_data_i * mul_b;
  end

  // Dropping the low bits of a two's complement product rounds toward minus infinity
  assign shifted = mul_q[PROD_W-1:FRAC_BITS];
  assign sum     = (tag2_q.first ? ACC_W'(0) : acc_q) + {{2{shifted[TERM_W-1]}}, shifted};
  assign upper   = sum[ACC_W-1:DATA_W-1];
  assign ovf     = !((&upper) || (~|upper));
  assign sat_val = !ovf ? sum[DATA_W-1:0] : (sum[ACC_W-1] ? S_MIN : S_MAX);
  assign wb      = tag2_q.valid && tag2_q.last;

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      acc_q <= sum;
    end
    if (wb && !tag2_q.to_mem) begin
      res_q[tag2_q.dst[3:2]] <= sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_flag_q  <= 1'b0;
      sat_seen_q <= 1'b0;
    end else begin
      if (clr_i) begin
        pt_flag_q  <= 1'b0;
        sat_seen_q <= 1'b0;
      end
      if (wb && ovf) begin
        if (tag2_q.to_mem) begin
          sat_seen_q <= 1'b1;
        end else begin
          pt_flag_q <= 1'b1;
        end
      end
    end
  end

  assign wr_en_o   = wb && tag2_q.to_mem;
  assign wr_addr_o = tag2_q.dst;
  assign wr_data_o = sat_val;
  assign res_x_o   = res_q[0];
  assign res_y_o   = res_q[1];
  assign res_z_o   = res_q[2];
  assign sat_o     = pt_flag_q || sat_seen_q;

endmodule

[src/ata_seq.sv]
// Sequencer: walks the matrix entries or point products and issues one term per cycle.
module ata_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     opcode_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output logic           load_out_o,
  output ata_pkg::term_t term_o
);
  import ata_pkg::*;

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic [1:0] term_q, term_d;
  logic       drain_q, drain_d;
  logic       entry_end;
  logic       done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_TRANSLATE;
      row_q   <= '0;
      col_q   <= '0;
      term_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      row_q   <= row_d;
      col_q   <= col_d;
      term_q  <= term_d;
      drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    row_d      = row_q;
    col_d      = col_q;
    term_d     = term_q;
    drain_d    = drain_q;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    term_o     = '0;
    entry_end  = 1'b0;
    done       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        row_d      = '0;
        col_d      = '0;
        term_d     = '0;
        // An undefined opcode is taken and dropped
        if (in_valid_i && (opcode_i == OP_TRANSLATE || opcode_i == OP_SCALE ||
                           opcode_i == OP_POINT)) begin
          op_d    = op_e'(opcode_i);
          state_d = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        term_o.valid   = 1'b1;
        term_o.arg_sel = row_q;
        term_o.dst     = {row_q, col_q};
        unique case (op_q)
          OP_TRANSLATE: begin
            // Entry plus translation times the bottom-row entry of the same column
            term_o.is_prod = (term_q != 2'd0);
            term_o.first   = (term_q == 2'd0);
            term_o.last    = (term_q == 2'd1);
            term_o.to_mem  = 1'b1;
            term_o.rd_addr = (term_q == 2'd0) ? {row_q, col_q} : {2'd3, col_q};
            entry_end      = (term_q == 2'd1);
            done           = entry_end && row_q == 2'd2 && col_q == 2'd3;
          end
          OP_SCALE: begin
            term_o.is_prod = 1'b1;
            term_o.first   = 1'b1;
            term_o.last    = 1'b1;
            term_o.to_mem  = 1'b1;
            term_o.rd_addr = {row_q, col_q};
            entry_end      = 1'b1;
            done           = row_q == 2'd2 && col_q == 2'd3;
          end
          OP_POINT: begin
            // Translation column first, then the three products
            term_o.is_prod = (term_q != 2'd0);
            term_o.first   = (term_q == 2'd0);
            term_o.last    = (term_q == 2'd3);
            term_o.to_mem  = 1'b0;
            term_o.arg_sel = term_q - 2'd1;
            term_o.dst     = {row_q, 2'd0};
            term_o.rd_addr = (term_q == 2'd0) ? {row_q, 2'd3} : {row_q, term_q - 2'd1};
            entry_end      = (term_q == 2'd3);
            done           = entry_end && row_q == 2'd2;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase

        term_d = entry_end ? 2'd0 : term_q + 2'd1;
        if (entry_end) begin
          if (op_q == OP_POINT) begin
            row_d = row_q + 2'd1;
          end else begin
            col_d = col_q + 2'd1;
            if (col_q == 2'd3) begin
              row_d = row_q + 2'd1;
            end
          end
        end
        if (done) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end
      end

      ST_DRAIN: begin
        // Hold until the last term has been written back
        if (drain_q) begin
          state_d = (op_q == OP_POINT) ? ST_OUT : ST_IDLE;
        end else begin
          drain_d = 1'b1;
        end
      end

      ST_OUT: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_o.valid && term_o.rd_addr[3:2] == 2'd3 |-> op_q == OP_TRANSLATE && term_o.is_prod)
    else $error("bottom row read outside a translate product");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out_o |-> op_q == OP_POINT)
    else $error("result loaded for a matrix update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_o.valid |-> !in_ready_o)
    else $error("request taken while terms are still issuing");

endmodule

[tb/tb_affine_transform_accumulator.sv]
// Self-checking testbench for the affine transform accumulator: directed and random requests.
module tb_affine_transform_accumulator;
  import ata_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam int                 N_RANDOM  = 1430;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } point_t;

  class transform_scoreboard;
    logic signed [31:0] mat [16];
    bit                 sat_seen;
    point_t             expected_points [$];
    int errors, n_translate, n_scale, n_point, n_unused, n_requests, n_checked, n_flagged;

    function new();
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? Q_ONE : '0;
      sat_seen = 0;
    endfunction

    // Exact product, then floor shift back to the fixed-point scale
    function longint fx_mul(logic signed [31:0] u, logic signed [31:0] v);
      longint prod;
      prod = longint'(u) * longint'(v);
      return prod >>> FRAC;
    endfunction

    function logic signed [31:0] clamp(longint s, inout bit flag);
      if (s > longint'(S32_MAX)) begin
        flag = 1;
        return S32_MAX;
      end
      if (s < longint'(S32_MIN)) begin
        flag = 1;
        return S32_MIN;
      end
      return s[31:0];
    endfunction

    function void left_multiply(logic signed [31:0] lhs [16]);
      logic signed [31:0] nxt [16];
      longint             acc;
      bit                 flag;
      flag = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fx_mul(lhs[i*4+k], mat[k*4+j]);
          nxt[i*4+j] = clamp(acc, flag);
        end
      end
      mat = nxt;
      if (flag) sat_seen = 1;
    endfunction

    function longint row_peak(int r);
      longint peak, mag;
      peak = 0;
      for (int k = 0; k < 4; k++) begin
        mag = longint'(mat[r*4+k]);
        if (mag < 0) mag = -mag;
        if (mag > peak) peak = mag;
      end
      return peak;
    endfunction

    function void note_request(logic [1:0] op, logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] c);
      logic signed [31:0] lhs [16];
      logic signed [31:0] pt [4];
      logic signed [31:0] o [3];
      point_t             res;
      longint             acc;
      bit                 flag;
      n_requests++;
      case (op)
        OP_TRANSLATE, OP_SCALE: begin
          for (int i = 0; i < 16; i++) lhs[i] = (i % 5 == 0) ? Q_ONE : '0;
          if (op == OP_TRANSLATE) begin
            lhs[3] = a; lhs[7] = b; lhs[11] = c;
            n_translate++;
          end else begin
            lhs[0] = a; lhs[5] = b; lhs[10] = c;
            n_scale++;
          end
          left_multiply(lhs);
        end
        OP_POINT: begin
          pt[0] = a; pt[1] = b; pt[2] = c; pt[3] = Q_ONE;
          flag = 0;
          // w row is never formed, so it cannot raise the flag
          for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += fx_mul(mat[i*4+k], pt[k]);
            o[i] = clamp(acc, flag);
          end
          res.x   = o[0];
          res.y   = o[1];
          res.z   = o[2];
          res.sat = flag | sat_seen;
          sat_seen = 0;
          expected_points.push_back(res);
          n_point++;
        end
        default: n_unused++;
      endcase
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td, logic flag_bit);
      point_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: point result with none outstanding: expected nothing, actual %h %h",
                 $time, flag_bit, td);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      n_checked++;
      if (flag_bit) n_flagged++;
      compare_field("out_x", want.x, td[31:0]);
      compare_field("out_y", want.y, td[63:32]);
      compare_field("out_z", want.z, td[95:64]);
      compare_field("saturated", 32'(want.sat), 32'(flag_bit));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  bit tx_no_idle;
  bit rx_no_idle;
  bit hold_off;

  transform_scoreboard sb = new();

  affine_transform_accumulator #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pick a scale that pulls the row back towards a useful magnitude
  function automatic logic signed [31:0] scale_factor(longint peak);
    int f;
    if (peak > (longint'(1) << 27)) f = $urandom_range(1 << 12, 1 << 15);
    else if (peak < (1 << 13)) f = $urandom_range(1 << 17, 1 << 20);
    else f = $urandom_range(1 << 14, 1 << 18);
    if ($urandom_range(0, 3) == 0) f = -f;
    return f;
  endfunction

  function automatic void pick_request(output logic [1:0] op, output logic signed [31:0] a,
                                       output logic signed [31:0] b,
                                       output logic signed [31:0] c);
    logic signed [31:0] v [3];
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 4) op = OP_UNUSED;
    else if (r < 34) op = OP_TRANSLATE;
    else if (r < 60) op = OP_SCALE;
    else op = OP_POINT;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 99) < 12) v[i] = $urandom;
      else if (op == OP_SCALE) v[i] = scale_factor(sb.row_peak(i));
      else v[i] = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    end
    a = v[0];
    b = v[1];
    c = v[2];
  endfunction

  task automatic send_request(logic [1:0] op, logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, a, b, c);
    if (sb.n_requests % 40 == 0) tx_no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: random stalls, plus one long hold-off below
  initial begin
    int stall;
    int n_taken;
    n_taken  = 0;
    m_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      while (hold_off) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      n_taken++;
      if (n_taken % 30 == 0) rx_no_idle = ($urandom_range(0, 3) == 0);
    end
  end

  // Starve the result side for a long stretch so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    while (sb.n_requests < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [1:0]         op;
    logic signed [31:0] a, b, c;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    rst_n    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity first, then extremes, saturation and clearing of the flag
    send_request(OP_POINT, 32'sh0, 32'sh0, 32'sh0);
    send_request(OP_POINT, S32_MAX, S32_MIN, Q_ONE);
    send_request(OP_POINT, S32_MIN, S32_MAX, -32'sd1);
    send_request(OP_UNUSED, 32'sh5a5a_a5a5, 32'sh7fff_0001, 32'sh8000_ffff);
    send_request(OP_POINT, Q_ONE, -Q_ONE, 32'sh0000_8000);
    send_request(OP_TRANSLATE, Q_ONE, -Q_ONE, 32'sh0002_0000);
    send_request(OP_POINT, Q_ONE, Q_ONE, Q_ONE);
    send_request(OP_SCALE, 32'sh0002_0000, 32'shffff_8000, 32'sh0003_0000);
    send_request(OP_POINT, -32'sd1, 32'sd1, Q_ONE);
    send_request(OP_TRANSLATE, S32_MAX, S32_MIN, 32'sh0);
    send_request(OP_POINT, 32'sh0, 32'sh0, 32'sh0);
    send_request(OP_POINT, 32'sh0, 32'sh0, 32'sh0);
    send_request(OP_SCALE, S32_MAX, S32_MAX, S32_MAX);
    send_request(OP_SCALE, 32'sd1, 32'sd1, 32'sd1);
    send_request(OP_POINT, S32_MAX, S32_MAX, S32_MAX);
    send_request(OP_SCALE, S32_MIN, S32_MIN, S32_MIN);
    send_request(OP_SCALE, 32'sh0000_0100, 32'sh0000_0100, 32'sh0000_0100);
    send_request(OP_POINT, S32_MIN, S32_MIN, S32_MIN);
    send_request(OP_TRANSLATE, S32_MIN, S32_MIN, S32_MIN);
    send_request(OP_UNUSED, -32'sd1, -32'sd1, -32'sd1);
    send_request(OP_SCALE, Q_ONE, Q_ONE, Q_ONE);
    send_request(OP_POINT, 32'sh0001_2345, 32'shfffe_dcba, 32'sh0000_0001);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick_request(op, a, b, c);
      send_request(op, a, b, c);
    end
    s_tvalid <= 1'b0;

    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests: %0d translate, %0d scale, %0d point, %0d unused opcode.",
             sb.n_requests, sb.n_translate, sb.n_scale, sb.n_point, sb.n_unused);
    $display("Checked %0d point results, %0d of them flagged as saturated; %0d errors.",
             sb.n_checked, sb.n_flagged, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
